@@ rtl/luhn_card_number_classifier_top_defines.svh @@
// assertion macros for the luhn card number classifier rtl
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_TOP_DEFINES_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_TOP_DEFINES_SVH

// property holds in the same cycle as its trigger
`define LCNC_ASSERT_SAME(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// property holds in the cycle after its trigger
`define LCNC_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/lcnc_pkg.sv @@
// types, constants and digit tables of the luhn card number classifier
`default_nettype none

package lcnc_pkg;

   localparam int DigitWidth   = 4;
   localparam int CountWidth   = 5;
   localparam int VerdictWidth = 2;

   localparam int MaxDigitsDefault = 19;

   // lengths that a class accepts
   localparam int LenShort = 13;
   localparam int LenMid   = 15;
   localparam int LenLong  = 16;

   // prefix digits
   localparam logic [DigitWidth-1:0] PrefixThree = 4'd3;
   localparam logic [DigitWidth-1:0] PrefixFour  = 4'd4;
   localparam logic [DigitWidth-1:0] PrefixFive  = 4'd5;
   localparam logic [DigitWidth-1:0] PrefixSeven = 4'd7;
   localparam logic [DigitWidth-1:0] PrefixOne   = 4'd1;

   localparam logic [DigitWidth-1:0] Radix = 4'd10;

   typedef logic [DigitWidth-1:0] digit_type;
   typedef logic [CountWidth-1:0] count_type;

   typedef enum logic [VerdictWidth-1:0] {
      VERDICT_INVALID = 2'd0,
      VERDICT_CLASS_A = 2'd1,
      VERDICT_CLASS_B = 2'd2,
      VERDICT_CLASS_C = 2'd3
   } verdict_type;

   // checksum contribution of a doubled digit: digit sum of 2d, mod 10
   function automatic digit_type dbl_contrib(input digit_type d);
      digit_type r;
      case (d)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd2;
         4'd2:    r = 4'd4;
         4'd3:    r = 4'd6;
         4'd4:    r = 4'd8;
         4'd5:    r = 4'd1;
         4'd6:    r = 4'd3;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd7;
         4'd9:    r = 4'd9;
         4'd10:   r = 4'd2;
         4'd11:   r = 4'd4;
         4'd12:   r = 4'd6;
         4'd13:   r = 4'd8;
         4'd14:   r = 4'd0;
         default: r = 4'd3;
      endcase
      return r;
   endfunction

   // checksum contribution of a plain digit, mod 10
   function automatic digit_type pln_contrib(input digit_type d);
      return (d >= Radix) ? d - Radix : d;
   endfunction

   // sum of two residues below ten, mod 10
   function automatic digit_type add_mod10(input digit_type a, input digit_type b);
      logic [DigitWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, Radix}) ? DigitWidth'(s - {1'b0, Radix}) : DigitWidth'(s);
   endfunction

endpackage

`default_nettype wire

@@ rtl/lcnc_chan_if.sv @@
// valid/ready channels for digit words and verdict words
`default_nettype none

interface lcnc_req_if;
   logic                 valid;
   logic                 ready;
   lcnc_pkg::digit_type  digit;
   logic                 last_digit;

   modport source (output valid, output digit, output last_digit, input ready);
   modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface lcnc_rsp_if;
   logic                   valid;
   logic                   ready;
   lcnc_pkg::verdict_type  verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

@@ rtl/luhn_card_number_classifier_top.sv @@
// top level of the luhn mod-10 card number classifier
//
//   channel   dir   words               handshake
//   req_bus   in    digit, last_digit   valid/ready, one digit per word
//   rsp_bus   out   verdict             valid/ready, one word per number
//
// a digit word is taken into an input register; a plain digit is folded into the running
// sums at the next edge, a last digit loads its verdict into the output register once
// that register has room; one digit word per cycle, sustained while no last digit waits;
// a verdict word is offered from the output register until it is taken with rsp_bus.ready
// a waiting verdict only holds a last digit word back, and the words behind it; plain digits before it keep flowing
// reset is synchronous, active high, and clears all control and running state
`default_nettype none

`include "luhn_card_number_classifier_top_defines.svh"

module luhn_card_number_classifier_top #(
   parameter int MAX_DIGITS = lcnc_pkg::MaxDigitsDefault
) (
   input  wire            clock,
   input  wire            reset,
   lcnc_req_if.sink       req_bus,
   lcnc_rsp_if.source     rsp_bus
);

   localparam int W = lcnc_pkg::CountWidth;
   localparam logic [W-1:0] MaxCount = W'(MAX_DIGITS);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   lcnc_pkg::digit_type   s1_digit_ff, s1_digit_in;
   logic                  s1_last_ff,  s1_last_in;

   // running state of the number being received
   lcnc_pkg::digit_type   sum_even_ff, sum_even_in;
   lcnc_pkg::digit_type   sum_odd_ff,  sum_odd_in;
   lcnc_pkg::count_type   count_ff,    count_in;
   lcnc_pkg::digit_type   lead_ff,     lead_in;
   lcnc_pkg::digit_type   second_ff,   second_in;

   // output register
   logic                  out_valid_ff,   out_valid_in;
   lcnc_pkg::verdict_type out_verdict_ff, out_verdict_in;

   logic                  out_free;
   logic                  s1_fire;
   logic                  req_fire;
   lcnc_pkg::digit_type   dbl_val;
   lcnc_pkg::digit_type   pln_val;
   lcnc_pkg::digit_type   even_upd;
   lcnc_pkg::digit_type   odd_upd;
   lcnc_pkg::digit_type   lead_upd;
   lcnc_pkg::digit_type   second_upd;
   lcnc_pkg::count_type   count_upd;
   lcnc_pkg::digit_type   total;
   lcnc_pkg::verdict_type verdict_upd;

   // handshake: a last digit word needs room in the output register
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.verdict = out_verdict_ff;

   // digit fold: position parity picks which sum doubles this digit
   always_comb begin
      dbl_val = lcnc_pkg::dbl_contrib(s1_digit_ff);
      pln_val = lcnc_pkg::pln_contrib(s1_digit_ff);

      if (count_ff[0]) begin
         even_upd = lcnc_pkg::add_mod10(sum_even_ff, pln_val);
         odd_upd  = lcnc_pkg::add_mod10(sum_odd_ff, dbl_val);
      end else begin
         even_upd = lcnc_pkg::add_mod10(sum_even_ff, dbl_val);
         odd_upd  = lcnc_pkg::add_mod10(sum_odd_ff, pln_val);
      end

      // capture the first two digits for the prefix check
      lead_upd   = (count_ff == '0) ? s1_digit_ff : lead_ff;
      second_upd = (count_ff == W'(1)) ? s1_digit_ff : second_ff;

      // length saturates, later digits reuse the last position
      count_upd = (count_ff < MaxCount) ? count_ff + W'(1) : count_ff;

      // even length means the first digit was doubled
      total = count_upd[0] ? odd_upd : even_upd;
   end

   lcnc_classify u_classify (
      .lead_digit   (lead_upd),
      .second_digit (second_upd),
      .length       (count_upd),
      .sum_ok       (total == '0),
      .verdict      (verdict_upd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_digit_in = s1_digit_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_digit_in = req_bus.digit;
         s1_last_in  = req_bus.last_digit;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      sum_even_in = sum_even_ff;
      sum_odd_in  = sum_odd_ff;
      count_in    = count_ff;
      lead_in     = lead_ff;
      second_in   = second_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            // number complete: start the next one from scratch
            sum_even_in = '0;
            sum_odd_in  = '0;
            count_in    = '0;
            lead_in     = '0;
            second_in   = '0;
         end else begin
            sum_even_in = even_upd;
            sum_odd_in  = odd_upd;
            count_in    = count_upd;
            lead_in     = lead_upd;
            second_in   = second_upd;
         end
      end

      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      if (s1_fire && s1_last_ff) begin
         out_valid_in   = 1'b1;
         out_verdict_in = verdict_upd;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sum_even_ff  <= '0;
         sum_odd_ff   <= '0;
         count_ff     <= '0;
         lead_ff      <= '0;
         second_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         sum_even_ff  <= sum_even_in;
         sum_odd_ff   <= sum_odd_in;
         count_ff     <= count_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_digit_ff    <= s1_digit_in;
      s1_last_ff     <= s1_last_in;
      out_verdict_ff <= out_verdict_in;
   end

   `LCNC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= MaxCount,
      "digit count ran past its limit")
   `LCNC_ASSERT_SAME(a_sums_residue, clock, reset, 1'b1,
      (sum_even_ff < lcnc_pkg::Radix) && (sum_odd_ff < lcnc_pkg::Radix),
      "running sum left the mod-10 range")
   `LCNC_ASSERT_NEXT(a_clear_after_last, clock, reset, s1_fire && s1_last_ff,
      (count_ff == '0) && (sum_even_ff == '0) && (sum_odd_ff == '0) && out_valid_ff,
      "state not cleared or verdict missing after last digit")
   `LCNC_ASSERT_NEXT(a_verdict_held, clock, reset, out_valid_ff && !rsp_bus.ready,
      out_valid_ff && (out_verdict_ff == $past(out_verdict_ff)),
      "waiting verdict was dropped or overwritten")

endmodule

`default_nettype wire

@@ rtl/lcnc_classify.sv @@
// issuer class decode from prefix, length and checksum result
`default_nettype none

module lcnc_classify (
   input  lcnc_pkg::digit_type    lead_digit,
   input  lcnc_pkg::digit_type    second_digit,
   input  lcnc_pkg::count_type    length,
   input  logic                   sum_ok,
   output lcnc_pkg::verdict_type  verdict
);

   localparam int W = lcnc_pkg::CountWidth;

   logic len_short;
   logic len_mid;
   logic len_long;
   logic class_a;
   logic class_b;
   logic class_c;

   always_comb begin
      len_short = (length == W'(lcnc_pkg::LenShort));
      len_mid   = (length == W'(lcnc_pkg::LenMid));
      len_long  = (length == W'(lcnc_pkg::LenLong));

      class_a = (lead_digit == lcnc_pkg::PrefixThree)
                && ((second_digit == lcnc_pkg::PrefixFour)
                    || (second_digit == lcnc_pkg::PrefixSeven))
                && len_mid;
      class_b = (lead_digit == lcnc_pkg::PrefixFive)
                && (second_digit >= lcnc_pkg::PrefixOne)
                && (second_digit <= lcnc_pkg::PrefixFive)
                && len_long;
      class_c = (lead_digit == lcnc_pkg::PrefixFour) && (len_short || len_long);

      if (!sum_ok) begin
         verdict = lcnc_pkg::VERDICT_INVALID;
      end else if (class_a) begin
         verdict = lcnc_pkg::VERDICT_CLASS_A;
      end else if (class_b) begin
         verdict = lcnc_pkg::VERDICT_CLASS_B;
      end else if (class_c) begin
         verdict = lcnc_pkg::VERDICT_CLASS_C;
      end else begin
         verdict = lcnc_pkg::VERDICT_INVALID;
      end
   end

endmodule

`default_nettype wire
